// File: hdl/assert_macros.svh
// Assertion macros used by the checker of the deframer.
// Needs nothing else; the clock and reset are handed in by the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while reset is released.
`define CCFD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CCFD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ccfd_pkg.sv
// Shared types, constants and CRC step functions of the frame deframer.
// Used by the top level, the parser, the result register and the checker of the block.
package ccfd_pkg;

  localparam int unsigned MaxPayloadDefault = 128;

  localparam logic [7:0]  StartByte = 8'hA5;
  localparam logic [7:0]  HcrcInit  = 8'hFF;
  localparam logic [15:0] FcrcInit  = 16'hFFFF;
  localparam logic [7:0]  Crc8Poly  = 8'h8C;    // 0x31 reflected
  localparam logic [15:0] Crc16Poly = 16'h8408; // 0x1021 reflected

  localparam int unsigned OutDataW = 48;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_GOOD      = 3'd1,
    KIND_HDR_ERR   = 3'd2,
    KIND_FRAME_ERR = 3'd3,
    KIND_TOO_LONG  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] command_id;
    logic [7:0]  payload_byte;
    logic [6:0]  byte_index;
    logic [7:0]  sequence_number;
    logic [7:0]  payload_length;
  } result_t;

  // One byte through the reflected CRC-8, bit by bit.
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ Crc8Poly) : (c >> 1);
    end
    return c;
  endfunction

  // One byte through the reflected CRC-16.
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ Crc16Poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hdl/crc_checked_frame_deframer_core.sv
// Top level of the CRC-checked frame deframer: input register, parser, result register.
// Depends on ccfd_pkg, ccfd_in_stage, ccfd_parser and ccfd_out_stage.
//
// Channel  Dir  Beat contents
// s_axis   in   tdata[7:0] received byte
// m_axis   out  tuser result kind; tdata command, payload byte, index, sequence, length
//
// Every received byte passes through the parser; a new beat is accepted every cycle while
// the output is not stalled. Each byte is held in the input register, and each result in
// the result register. Bytes that cause no result still pass through the parser.
// Reset returns the parser to hunting for the start byte and empties both registers.
// A stalled output holds the parser and then the input register; no beat is dropped.
module crc_checked_frame_deframer_core #(
  parameter int unsigned MaxPayload = ccfd_pkg::MaxPayloadDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // [7:0] rx_byte
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [15:0] command_id, [23:16] payload_byte, [30:24] byte_index,
  // [38:31] sequence_number, [46:39] payload_length, [47] zero
  output logic [ccfd_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic [2:0]                    m_axis_tuser_o   // [2:0] result_kind
);
  import ccfd_pkg::*;

  logic    in_valid;
  logic [7:0] in_byte;
  logic    out_ready;
  logic    step;
  logic    res_valid;
  result_t res;

  assign step = in_valid && out_ready;

  ccfd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_data_i  (s_axis_tdata_i),
    .take_i    (step),
    .valid_o   (in_valid),
    .data_o    (in_byte)
  );

  ccfd_parser #(
    .MaxPayload (MaxPayload)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ccfd_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (res_valid),
    .res_i     (res),
    .ready_o   (out_ready),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_user_o  (m_axis_tuser_o)
  );

endmodule

// File: hdl/ccfd_in_stage.sv
// Input register of the deframer: holds one received byte until the parser takes it.
// Depends on nothing but the clock and reset.
module ccfd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_data_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] data_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;

  // Refill in the same cycle the held beat is consumed.
  assign s_ready_o = !valid_q || take_i;
  assign valid_d   = s_ready_o ? s_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      data_q <= s_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hdl/ccfd_parser.sv
// Frame parser: phase machine, header CRC-8, frame CRC-16 and payload counting.
// Uses ccfd_pkg for the result type, kinds and CRC step functions.
module ccfd_parser #(
  parameter int unsigned MaxPayload = ccfd_pkg::MaxPayloadDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        rx_byte_i,
  output logic              res_valid_o,
  output ccfd_pkg::result_t res_o
);
  import ccfd_pkg::*;

  localparam int unsigned LenBits = $clog2(MaxPayload + 1);
  localparam int unsigned CntW    = (LenBits > 3) ? LenBits : 3;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_CMD     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TRAILER = 3'd4
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     len_q, len_d;
  logic [7:0]      seq_q, seq_d;
  logic [7:0]      hcrc_q, hcrc_d;
  logic [15:0]     fcrc_q, fcrc_d;
  logic [15:0]     cmd_q, cmd_d;
  logic [7:0]      trl_q, trl_d;

  logic            emit;
  kind_e           kind;
  logic [7:0]      pay;
  logic [6:0]      idx;
  logic [15:0]     fcrc_upd;
  logic [CntW-1:0] cnt_inc;
  logic [31:0]     cnt_ext;

  assign fcrc_upd = crc16_step(fcrc_q, rx_byte_i);
  assign cnt_inc  = cnt_q + CntW'(1);
  assign cnt_ext  = 32'(cnt_q);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    seq_d   = seq_q;
    hcrc_d  = hcrc_q;
    fcrc_d  = fcrc_q;
    cmd_d   = cmd_q;
    trl_d   = trl_q;
    emit    = 1'b0;
    kind    = KIND_DATA;
    pay     = 8'h00;
    idx     = 7'd0;
    unique case (phase_q)
      PH_HEADER: begin
        fcrc_d = fcrc_upd;
        if (cnt_q < CntW'(4)) begin
          if (cnt_q == CntW'(1)) begin
            len_d = {8'h00, rx_byte_i};
          end else if (cnt_q == CntW'(2)) begin
            len_d = {rx_byte_i, len_q[7:0]};
          end else begin
            seq_d = rx_byte_i;
          end
          hcrc_d = crc8_step(hcrc_q, rx_byte_i);
          cnt_d  = cnt_inc;
        end else if (rx_byte_i != hcrc_q) begin
          emit    = 1'b1;
          kind    = KIND_HDR_ERR;
          phase_d = PH_HUNT;
        end else if (len_q > 16'(MaxPayload)) begin
          emit    = 1'b1;
          kind    = KIND_TOO_LONG;
          phase_d = PH_HUNT;
        end else begin
          cnt_d   = '0;
          phase_d = PH_CMD;
        end
      end
      PH_CMD: begin
        fcrc_d = fcrc_upd;
        if (cnt_q == '0) begin
          cmd_d = {8'h00, rx_byte_i};
          cnt_d = CntW'(1);
        end else begin
          cmd_d   = {rx_byte_i, cmd_q[7:0]};
          cnt_d   = '0;
          phase_d = (len_q != 16'd0) ? PH_PAYLOAD : PH_TRAILER;
        end
      end
      PH_PAYLOAD: begin
        fcrc_d = fcrc_upd;
        emit   = 1'b1;
        kind   = KIND_DATA;
        pay    = rx_byte_i;
        idx    = cnt_ext[6:0];
        cnt_d  = cnt_inc;
        if (16'(cnt_inc) >= len_q) begin
          cnt_d   = '0;
          phase_d = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        if (cnt_q == '0) begin
          trl_d = rx_byte_i;
          cnt_d = CntW'(1);
        end else begin
          emit    = 1'b1;
          kind    = ((trl_q == fcrc_q[7:0]) && (rx_byte_i == fcrc_q[15:8]))
                    ? KIND_GOOD : KIND_FRAME_ERR;
          phase_d = PH_HUNT;
        end
      end
      default: begin
        phase_d = PH_HUNT;
        if (rx_byte_i == StartByte) begin
          hcrc_d  = crc8_step(HcrcInit, rx_byte_i);
          fcrc_d  = crc16_step(FcrcInit, rx_byte_i);
          len_d   = '0;
          seq_d   = '0;
          cmd_d   = '0;
          trl_d   = '0;
          cnt_d   = CntW'(1);
          phase_d = PH_HEADER;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      len_q   <= '0;
      seq_q   <= '0;
      hcrc_q  <= HcrcInit;
      fcrc_q  <= FcrcInit;
      cmd_q   <= '0;
      trl_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      seq_q   <= seq_d;
      hcrc_q  <= hcrc_d;
      fcrc_q  <= fcrc_d;
      cmd_q   <= cmd_d;
      trl_q   <= trl_d;
    end
  end

  // The command, sequence and length fields show the frame registers as they stand before this beat.
  assign res_valid_o           = step_i && emit;
  assign res_o.kind            = kind;
  assign res_o.command_id      = cmd_q;
  assign res_o.payload_byte    = pay;
  assign res_o.byte_index      = idx;
  assign res_o.sequence_number = seq_q;
  assign res_o.payload_length  = (len_q > 16'd255) ? 8'hFF : len_q[7:0];

endmodule

// File: hdl/ccfd_out_stage.sv
// Result register of the deframer: holds one result beat until the sink takes it.
// Uses ccfd_pkg for the result type and the output data width.
module ccfd_out_stage (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  ccfd_pkg::result_t                  res_i,
  output logic                               ready_o,
  output logic                               m_valid_o,
  input  logic                               m_ready_i,
  output logic [ccfd_pkg::OutDataW-1:0]      m_data_o,
  output logic [2:0]                         m_user_o
);
  import ccfd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign ready_o = !valid_q || m_ready_i;
  assign valid_d = load_i ? 1'b1 : (m_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_user_o  = res_q.kind;
  assign m_data_o  = {1'b0, res_q.payload_length, res_q.sequence_number,
                      res_q.byte_index, res_q.payload_byte, res_q.command_id};

endmodule

// File: hdl/ccfd_checker.sv
// Port-level checks of the deframer top level, attached by the bind below.
// Depends on ccfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ccfd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [ccfd_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [2:0]                    m_axis_tuser_o
);
  import ccfd_pkg::*;

  logic       is_data;
  logic       no_cmd;
  logic [7:0] pay;
  logic [6:0] idx;
  logic [7:0] len;
  logic [15:0] cmd;

  assign is_data = m_axis_tuser_o == KIND_DATA;
  assign no_cmd  = (m_axis_tuser_o == KIND_HDR_ERR) || (m_axis_tuser_o == KIND_TOO_LONG);
  assign cmd     = m_axis_tdata_o[15:0];
  assign pay     = m_axis_tdata_o[23:16];
  assign idx     = m_axis_tdata_o[30:24];
  assign len     = m_axis_tdata_o[46:39];

  // The result register is cleared as soon as reset is asserted, so the check is non-overlapping.
  `CCFD_ASSERT_ALWAYS(a_idle_in_reset, clk_i,
    !rst_ni |=> !m_axis_tvalid_o, "result during reset")

  `CCFD_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o),
    "stalled result beat changed")

  `CCFD_ASSERT(a_index_in_range, clk_i, rst_ni,
    m_axis_tvalid_o && is_data |-> (len != 8'd0) && ({1'b0, idx} < len),
    "payload index beyond header length")

  `CCFD_ASSERT(a_status_no_data, clk_i, rst_ni,
    m_axis_tvalid_o && !is_data |-> (pay == 8'h00) && (idx == 7'd0),
    "status beat carries payload fields")

  `CCFD_ASSERT(a_hdr_fail_no_cmd, clk_i, rst_ni,
    m_axis_tvalid_o && no_cmd |-> cmd == 16'h0000,
    "header failure carries a command id")

endmodule

bind crc_checked_frame_deframer_core ccfd_checker u_ccfd_checker (.*);
